### hw/rtl/trsd_pkg.sv
// ----------------------------------------------------------------------------
// trsd_pkg: shared types and constants for the token repeat and stop detector
// Status codes, register indexes, field widths and the cell control word.
// ----------------------------------------------------------------------------
package trsd_pkg;

   // field widths
   localparam int TOKEN_W  = 17;
   localparam int NGRAM_W  = 6;
   localparam int LIMIT_W  = 11;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 3;

   // default sizes
   localparam int HISTORY_DEPTH_DEF = 1024;
   localparam int MAX_NGRAM_DEF     = 32;

   // register reset values
   localparam logic [NGRAM_W-1:0] NGRAM_RST = NGRAM_W'(6);
   localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(1024);
   localparam logic [TOKEN_W-1:0] END_TOKEN_RST = TOKEN_W'(120020);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NGRAM_LEN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOKEN_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_TOKEN_A = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_TOKEN_B = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_END_TOKEN_C = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_CONTINUE = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_END      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_REPEAT   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_LIMIT    = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_CANCEL   = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_IDLE     = 3'd5;

   // control for one compare cell
   typedef struct packed {
      logic shift_win;
      logic shift_tail;
   } cell_ctl_type;

endpackage

### hw/rtl/trsd_cell.sv
// ----------------------------------------------------------------------------
// trsd_cell: one compare cell of the n-gram chain
// Holds one scan window token and one tail token, both shifting along the row,
// and flags when the two are equal.
// ----------------------------------------------------------------------------
module trsd_cell
   import trsd_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [TOKEN_W-1:0] win_prev,
   input  logic [TOKEN_W-1:0] tail_prev,
   output logic [TOKEN_W-1:0] win_out,
   output logic [TOKEN_W-1:0] tail_out,
   output logic               match
);

   logic [TOKEN_W-1:0] win_ff, win_in;
   logic [TOKEN_W-1:0] tail_ff, tail_in;

   // next values: take the neighbor's token on a shift
   always_comb begin
      win_in  = ctl.shift_win  ? win_prev  : win_ff;
      tail_in = ctl.shift_tail ? tail_prev : tail_ff;
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      tail_ff <= tail_in;
   end

   assign win_out  = win_ff;
   assign tail_out = tail_ff;
   assign match    = (win_ff == tail_ff);

endmodule

### hw/rtl/token_repeat_stop_detector.sv
// ----------------------------------------------------------------------------
// token_repeat_stop_detector: end, limit, cancel and repeat check per token
// Response: registered at accept when no repeat scan runs; a scan reads up to
//   n - k entries (n stored tokens, k n-gram length), one history read per cycle.
// Throughput: one word per cycle without scan while the response is taken,
//   otherwise the next word waits for the scan on the single read port.
// Reset: synchronous, clears the registers to their defaults, no active
//   request and an empty count; history memory is not cleared.
// ----------------------------------------------------------------------------
module token_repeat_stop_detector
   import trsd_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int MAX_NGRAM     = MAX_NGRAM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request side
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,  // token_id[16:0], zero fill
   input  logic [1:0]           req_tuser,  // new_request[0], cancel_flag[1]
   // response side
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,  // status[2:0], accepted_count[13:3]
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TOKEN_W-1:0]   csr_data
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int KW = $clog2(MAX_NGRAM + 1);
   localparam int WW = CW + KW + 2;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   // registers
   logic [NGRAM_W-1:0] ngram_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [TOKEN_W-1:0] end_a_ff, end_b_ff, end_c_ff;

   logic               state_ff, state_in;
   logic               active_ff, active_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CW-1:0]      last_ff, last_in;
   logic [CW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic               issue_ff, issue_in;
   logic               p1_valid_ff, p1_valid_in;
   logic               p1_last_ff, p1_last_in;
   logic [CW-1:0]      p1_idx_ff, p1_idx_in;
   logic               p2_valid_ff, p2_valid_in;
   logic               p2_last_ff, p2_last_in;
   logic [CW-1:0]      p2_idx_ff, p2_idx_in;
   logic               hits_ff, hits_in;

   logic [TOKEN_W-1:0] mem [HISTORY_DEPTH];
   logic [TOKEN_W-1:0] rd_data_ff;

   // request fields
   logic [TOKEN_W-1:0] tok;
   logic               start, cancel;
   assign tok    = req_tdata[TOKEN_W-1:0];
   assign start  = req_tuser[0];
   assign cancel = req_tuser[1];

   logic req_fire, rsp_free;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // effective limit and n-gram length
   logic [CW-1:0] lim;
   logic [KW-1:0] k_sat;
   always_comb begin
      if (WW'(limit_ff) > WW'(HISTORY_DEPTH)) lim = CW'(HISTORY_DEPTH);
      else lim = CW'(limit_ff);
      if (WW'(ngram_ff) > WW'(MAX_NGRAM)) k_sat = KW'(MAX_NGRAM);
      else k_sat = KW'(ngram_ff);
   end

   // decision at accept
   logic          act, append, need_scan, is_end;
   logic [CW-1:0] cnt_eff, n_new;
   logic [STATUS_W-1:0] acc_status;
   always_comb begin
      cnt_eff   = start ? '0 : count_ff;
      act       = start || active_ff;
      n_new     = cnt_eff + CW'(1);
      is_end    = (tok == end_a_ff) || (tok == end_b_ff) || (tok == end_c_ff);
      append    = 1'b0;
      need_scan = 1'b0;
      if (!act) acc_status = STAT_IDLE;
      else if (cnt_eff >= lim) acc_status = STAT_LIMIT;
      else if (cancel) acc_status = STAT_CANCEL;
      else if (is_end) acc_status = STAT_END;
      else begin
         append    = 1'b1;
         need_scan = (k_sat != '0) && (WW'(n_new) >= WW'(k_sat) * WW'(3));
         acc_status = (n_new >= lim) ? STAT_LIMIT : STAT_CONTINUE;
      end
   end

   // chain of compare cells
   cell_ctl_type       cctl;
   logic [TOKEN_W-1:0] win_q  [MAX_NGRAM];
   logic [TOKEN_W-1:0] tail_q [MAX_NGRAM];
   logic [MAX_NGRAM-1:0] match;

   assign cctl.shift_win  = p1_valid_ff;
   assign cctl.shift_tail = req_fire && append;

   for (genvar j = 0; j < MAX_NGRAM; j++) begin : g_cell
      trsd_cell u_cell (
         .clock     (clock),
         .ctl       (cctl),
         .win_prev  ((j == 0) ? rd_data_ff : win_q[(j == 0) ? 0 : j - 1]),
         .tail_prev ((j == 0) ? tok        : tail_q[(j == 0) ? 0 : j - 1]),
         .win_out   (win_q[j]),
         .tail_out  (tail_q[j]),
         .match     (match[j])
      );
   end

   // all cells below k agree
   logic all_eq;
   always_comb begin
      all_eq = 1'b1;
      for (int j = 0; j < MAX_NGRAM; j++) begin
         if (WW'(j) < WW'(k_sat) && !match[j]) all_eq = 1'b0;
      end
   end

   logic hit, done, rep;
   assign hit  = p2_valid_ff && (WW'(p2_idx_ff) + WW'(1) >= WW'(k_sat)) && all_eq;
   assign rep  = hit && hits_ff;
   assign done = (state_ff == ST_SCAN) && (rep || (p2_valid_ff && p2_last_ff));

   // history memory
   always_ff @(posedge clock) begin
      if (req_fire && append) mem[cnt_eff[AW-1:0]] <= tok;
      if (issue_ff) rd_data_ff <= mem[rd_ptr_ff[AW-1:0]];
   end

   // control next state
   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      last_in       = last_ff;
      rd_ptr_in     = rd_ptr_ff;
      issue_in      = issue_ff;
      p1_valid_in   = issue_ff;
      p1_last_in    = issue_ff && (rd_ptr_ff == last_ff);
      p1_idx_in     = rd_ptr_ff;
      p2_valid_in   = p1_valid_ff;
      p2_last_in    = p1_last_ff;
      p2_idx_in     = p1_idx_ff;
      hits_in       = hits_ff || hit;
      if (issue_ff) begin
         rd_ptr_in = rd_ptr_ff + CW'(1);
         if (rd_ptr_ff == last_ff) issue_in = 1'b0;
      end
      if (req_fire) begin
         count_in = append ? n_new : cnt_eff;
         if (need_scan) begin
            state_in  = ST_SCAN;
            active_in = 1'b1;
            last_in   = n_new - CW'(k_sat) - CW'(1);
            rd_ptr_in = '0;
            issue_in  = 1'b1;
            hits_in   = 1'b0;
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = acc_status;
            active_in     = (acc_status == STAT_CONTINUE);
         end
      end
      // scan finished: post result and flush the pipe
      if (done) begin
         state_in      = ST_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_status_in = rep ? STAT_REPEAT :
                         ((count_ff >= lim) ? STAT_LIMIT : STAT_CONTINUE);
         active_in     = (rsp_status_in == STAT_CONTINUE);
         issue_in      = 1'b0;
         p1_valid_in   = 1'b0;
         p2_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         hits_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_ff     <= issue_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         hits_ff      <= hits_in;
      end
   end

   // payload and scan bookkeeping
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      last_ff       <= last_in;
      rd_ptr_ff     <= rd_ptr_in;
      p1_last_ff    <= p1_last_in;
      p1_idx_ff     <= p1_idx_in;
      p2_last_ff    <= p2_last_in;
      p2_idx_ff     <= p2_idx_in;
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ngram_ff <= NGRAM_RST;
         limit_ff <= LIMIT_RST;
         end_a_ff <= END_TOKEN_RST;
         end_b_ff <= END_TOKEN_RST;
         end_c_ff <= END_TOKEN_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NGRAM_LEN:   ngram_ff <= csr_data[NGRAM_W-1:0];
            CSR_TOKEN_LIMIT: limit_ff <= csr_data[LIMIT_W-1:0];
            CSR_END_TOKEN_A: end_a_ff <= csr_data;
            CSR_END_TOKEN_B: end_b_ff <= csr_data;
            CSR_END_TOKEN_C: end_c_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // response word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, LIMIT_W'(count_ff), rsp_status_ff};

   // checks
   a_scan_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_valid_ff)
      else $error("response pending during scan");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      WW'(count_ff) <= WW'(HISTORY_DEPTH))
      else $error("history count beyond depth");
   a_continue_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_CONTINUE) |-> active_ff)
      else $error("continue without active request");
   a_stop_inactive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STAT_CONTINUE && state_ff == ST_IDLE)
      |-> !active_ff)
      else $error("stop left request active");

endmodule

### tb/tb_token_repeat_stop_detector.sv
// ----------------------------------------------------------------------------
// tb_token_repeat_stop_detector: self-checking bench for the stop detector
// Streams token words with start and cancel flags through the block, predicts
// status and accepted count per word and compares every response in order.
// ----------------------------------------------------------------------------
module tb_token_repeat_stop_detector;
   import trsd_pkg::*;

   localparam int DEPTH     = 1024;
   localparam int NGRAM_MAX = 32;
   localparam int WATCHDOG  = 20000;

   typedef struct packed {
      logic [TOKEN_W-1:0] token;
      logic               start;
      logic               cancel;
   } token_word_type;

   // count in the upper bits, status in the lowest bits of the response word
   typedef struct packed {
      logic [LIMIT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } verdict_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [23:0]          req_tdata;
   logic [1:0]           req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [15:0]          rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TOKEN_W-1:0]   csr_data;

   token_repeat_stop_detector i_dut (.*);

   // predictor state
   logic [NGRAM_W-1:0] ngram_len;
   logic [LIMIT_W-1:0] token_limit;
   logic [TOKEN_W-1:0] end_a, end_b, end_c;
   logic [TOKEN_W-1:0] history [DEPTH];
   int                 hist_count;
   bit                 active;

   token_word_type pending_words[$];
   verdict_type    expected_verdicts[$];
   int             errors;
   int             stall_cycles;
   int             idle_cycles;
   bit             calm;
   bit             done;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit tail_repeats();
      int k;
      int tail;
      int hits;
      bit same;
      k = (ngram_len > NGRAM_MAX) ? NGRAM_MAX : ngram_len;
      if (k == 0 || hist_count < k * 3) return 1'b0;
      tail = hist_count - k;
      hits = 0;
      for (int s = 0; s + k <= tail; s++) begin
         same = 1'b1;
         for (int j = 0; j < k; j++)
            if (history[s + j] != history[tail + j]) same = 1'b0;
         if (same) begin
            hits++;
            if (hits >= 2) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic verdict_type judge_token(token_word_type w);
      verdict_type v;
      int          lim;
      lim = (token_limit > DEPTH) ? DEPTH : token_limit;
      if (w.start) begin
         hist_count = 0;
         active = 1'b1;
      end
      if (!active) v.status = STAT_IDLE;
      else if (hist_count >= lim) v.status = STAT_LIMIT;
      else if (w.cancel) v.status = STAT_CANCEL;
      else if (w.token == end_a || w.token == end_b || w.token == end_c)
         v.status = STAT_END;
      else begin
         history[hist_count] = w.token;
         hist_count++;
         if (tail_repeats()) v.status = STAT_REPEAT;
         else if (hist_count >= lim) v.status = STAT_LIMIT;
         else v.status = STAT_CONTINUE;
      end
      if (v.status != STAT_CONTINUE) active = 1'b0;
      v.count = LIMIT_W'(hist_count);
      return v;
   endfunction

   // driver: one word from the queue, random gaps unless calm
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
         // hold the word
      end else if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
         token_word_type w;
         w = pending_words.pop_front();
         expected_verdicts = {expected_verdicts, judge_token(w)};
         req_tvalid <= 1'b1;
         req_tdata  <= {7'd0, w.token};
         req_tuser  <= {w.cancel, w.start};
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // response ready, with one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (stall_cycles > 0) begin
         stall_cycles <= stall_cycles - 1;
         rsp_tready <= 1'b0;
      end else rsp_tready <= calm || ($urandom_range(99) >= 31);
   end

   // monitor
   always @(posedge clock) begin
      verdict_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = verdict_type'(rsp_tdata[13:0]);
         if (expected_verdicts.size() == 0) begin
            $error("response with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_verdicts.pop_front();
            if (got.status != want.status) begin
               $error("status expected %0d actual %0d", want.status, got.status);
               errors++;
            end
            if (got.count != want.count) begin
               $error("accepted_count expected %0d actual %0d", want.count, got.count);
               errors++;
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || stall_cycles > 0 || done)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic add_word(logic [TOKEN_W-1:0] t, bit s, bit c);
      token_word_type w;
      w.token = t;
      w.start = s;
      w.cancel = c;
      pending_words = {pending_words, w};
   endtask

   task automatic drain();
      wait (pending_words.size() == 0);
      @(posedge clock);
      while (req_tvalid || expected_verdicts.size() > 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [TOKEN_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_NGRAM_LEN:   ngram_len = val[NGRAM_W-1:0];
         CSR_TOKEN_LIMIT: token_limit = val[LIMIT_W-1:0];
         CSR_END_TOKEN_A: end_a = val;
         CSR_END_TOKEN_B: end_b = val;
         default:         end_c = val;
      endcase
   endtask

   // random token from a small alphabet so repeats happen, or a wide id
   function automatic logic [TOKEN_W-1:0] pick_token(int alphabet);
      if ($urandom_range(9) == 0) return TOKEN_W'($urandom);
      return TOKEN_W'($urandom_range(alphabet - 1) + 1);
   endfunction

   task automatic random_requests(int words, int alphabet);
      int n;
      n = 0;
      while (n < words) begin
         int len;
         len = $urandom_range(60, 4);
         add_word(pick_token(alphabet), 1'b1, 1'b0);
         for (int i = 1; i < len; i++) begin
            int r;
            r = $urandom_range(99);
            if (r < 2) add_word(pick_token(alphabet), 1'b0, 1'b1);
            else if (r < 4) add_word(end_a, 1'b0, 1'b0);
            else if (r < 6) add_word(pick_token(alphabet), 1'b1, 1'($urandom_range(1)));
            else add_word(pick_token(alphabet), 1'b0, 1'b0);
         end
         n += len;
         // stray words between requests
         if ($urandom_range(3) == 0)
            add_word(pick_token(alphabet), 1'b0, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      errors = 0;
      stall_cycles = 0;
      calm = 1'b0;
      done = 1'b0;
      idle_cycles = 0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_NGRAM_LEN;
      csr_data = '0;
      ngram_len = NGRAM_RST;
      token_limit = LIMIT_RST;
      end_a = END_TOKEN_RST;
      end_b = END_TOKEN_RST;
      end_c = END_TOKEN_RST;
      hist_count = 0;
      active = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults, idle word, extremes, cancel, end token, repeat
      add_word(17'h1FFFF, 1'b0, 1'b1);
      add_word(17'd0, 1'b1, 1'b0);
      add_word(17'h1FFFF, 1'b0, 1'b0);
      add_word(END_TOKEN_RST, 1'b0, 1'b0);
      add_word(17'd5, 1'b0, 1'b0);
      add_word(17'd5, 1'b1, 1'b1);
      for (int i = 0; i < 18; i++) add_word(TOKEN_W'(7 + (i % 6)), i == 0, 1'b0);
      drain();

      // limit of one and n-gram of one, limit met on the first word
      write_reg(CSR_TOKEN_LIMIT, 17'd1);
      write_reg(CSR_NGRAM_LEN, 17'd1);
      add_word(17'd3, 1'b1, 1'b0);
      add_word(17'd4, 1'b0, 1'b0);
      add_word(17'd4, 1'b1, 1'b0);
      drain();
      // limit raised between requests, zero limit, saturated n-gram
      write_reg(CSR_TOKEN_LIMIT, 17'd20);
      add_word(17'd9, 1'b1, 1'b0);
      add_word(17'd9, 1'b0, 1'b0);
      drain();
      write_reg(CSR_TOKEN_LIMIT, 17'd0);
      add_word(17'd9, 1'b0, 1'b1);
      add_word(17'd9, 1'b1, 1'b0);
      drain();
      write_reg(CSR_TOKEN_LIMIT, 17'h7FF);
      write_reg(CSR_NGRAM_LEN, 17'h3F);
      write_reg(CSR_END_TOKEN_A, 17'd0);
      write_reg(CSR_END_TOKEN_B, 17'h1FFFF);
      write_reg(CSR_END_TOKEN_C, 17'd2);
      add_word(17'd1, 1'b1, 1'b0);
      add_word(17'd2, 1'b0, 1'b0);
      drain();

      // random phases with varied settings, one long response stall
      write_reg(CSR_NGRAM_LEN, 17'd2);
      write_reg(CSR_TOKEN_LIMIT, 17'd40);
      stall_cycles = 300;
      random_requests(150, 4);
      drain();
      write_reg(CSR_NGRAM_LEN, 17'd0);
      write_reg(CSR_TOKEN_LIMIT, 17'd1024);
      write_reg(CSR_END_TOKEN_A, 17'd100);
      random_requests(130, 200);
      drain();
      // quiet stretch with no idling
      calm = 1'b1;
      write_reg(CSR_NGRAM_LEN, 17'd3);
      write_reg(CSR_END_TOKEN_B, 17'd50);
      random_requests(130, 3);
      drain();
      calm = 1'b0;
      write_reg(CSR_NGRAM_LEN, 17'd32);
      write_reg(CSR_END_TOKEN_C, 17'd60);
      random_requests(130, 2);
      drain();

      done = 1'b1;
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
